[rtl/sss_pkg.sv]
// Shared types and codes for the substring search block.
`timescale 1ns / 1ps

package sss_pkg;

	typedef logic [7:0] byte_t;

	// Opcode of an input item.
	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	// Shift controls broadcast to every cell of the chain.
	typedef struct packed {
		logic pat_shift;
		logic txt_shift;
	} cell_ctl_t;

endpackage

[rtl/sss_in_if.sv]
// Input channel: pattern and text bytes with valid/ready handshake.
`timescale 1ns / 1ps

interface sss_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, opcode, data_byte, last, input ready);
	modport sink   (input valid, opcode, data_byte, last, output ready);
endinterface

[rtl/sss_out_if.sv]
// Result channel: found flag and start index with valid/ready handshake.
`timescale 1ns / 1ps

interface sss_out_if #(
	parameter int INDEX_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic                  found;
	logic [INDEX_BITS-1:0] start_pos;

	modport source (output valid, found, start_pos, input ready);
	modport sink   (input valid, found, start_pos, output ready);
endinterface

[rtl/sss_cell.sv]
// One cell of the search chain: a pattern byte, a window byte and their compare.
`timescale 1ns / 1ps

module sss_cell
	import sss_pkg::*;
#(
	parameter int CELL_IDX = 0,
	parameter int LEN_W    = 6
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  byte_t            pat_in,
	input  byte_t            win_in,
	input  logic [LEN_W-1:0] len,
	output byte_t            pat,
	output byte_t            win,
	output logic             eq
);

	localparam logic [LEN_W-1:0] IDX_C = LEN_W'(CELL_IDX);

	byte_t pat_q;
	byte_t win_q;

	always_ff @(posedge clk) begin
		if (ctl.pat_shift) begin
			pat_q <= pat_in;
		end
		if (ctl.txt_shift) begin
			win_q <= win_in;
		end
	end

	// The compare looks at the byte this cell will hold after the current shift,
	// so the position ending at the incoming byte is tested in the same cycle.
	// Cells at or beyond the pattern length always agree.
	assign eq  = (len <= IDX_C) || (pat_q == win_in);
	assign pat = pat_q;
	assign win = win_q;

endmodule

[rtl/substring_search_first_last.sv]
// Top level of the byte substring search with first or last occurrence report.
`timescale 1ns / 1ps

// Load a pattern of 1 to MAX_PATTERN bytes (opcode 0, last on the final byte), then
// stream text bytes (opcode 1). Every cell of the chain holds one pattern byte aligned
// to one window byte, so each text byte is compared at every cell in the cycle it is
// accepted, and the block takes one item per clock. The result of the text byte marked
// last is registered and offered on the next cycle; a new item is taken while that
// result waits, except when another result would need the occupied output register.
// The longest path is the byte compare in each cell, the AND across all cells and the
// index range check. The search_last register selects the first (0) or last (1)
// occurrence; write it only while the block is idle. No pass is needed after reset.
module substring_search_first_last
	import sss_pkg::*;
#(
	parameter int MAX_PATTERN = 32,
	parameter int INDEX_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	sss_in_if.sink    item,
	sss_out_if.source result
);

	localparam int               LEN_W    = $clog2(MAX_PATTERN + 1);
	localparam longint unsigned  IDX_MAX  = (64'd1 << INDEX_BITS) - 64'd1;
	localparam longint unsigned  TEXT_CAP = IDX_MAX + MAX_PATTERN;
	localparam int               CNT_W    = $clog2(TEXT_CAP + 1);
	localparam logic [CNT_W-1:0] CAP_C    = CNT_W'(TEXT_CAP);
	localparam logic [CNT_W-1:0] IMAX_C   = CNT_W'(IDX_MAX);
	localparam logic [LEN_W-1:0] MAXL_C   = LEN_W'(MAX_PATTERN);

	logic                  search_last_q;
	logic [LEN_W-1:0]      len_q;
	logic                  closed_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  seen_q;
	logic [INDEX_BITS-1:0] start_q;

	logic                  res_valid_q;
	logic                  res_found_q;
	logic [INDEX_BITS-1:0] res_start_q;

	logic                  accept;
	logic                  is_pat;
	logic                  is_txt;
	cell_ctl_t             ctl;
	logic [CNT_W-1:0]      n;
	logic [CNT_W-1:0]      len_ext;
	logic [CNT_W-1:0]      diff;
	logic                  hit;
	logic                  take_new;
	logic [MAX_PATTERN-1:0] eq_w;

	byte_t pat_w [MAX_PATTERN];
	byte_t win_w [MAX_PATTERN];

	// Only a text byte that ends a text needs the output register.
	assign item.ready = !res_valid_q || result.ready
		|| !((item.opcode == OP_TEXT) && item.last);
	assign accept     = item.valid && item.ready;
	assign is_pat     = accept && (item.opcode == OP_PATTERN);
	assign is_txt     = accept && (item.opcode == OP_TEXT);

	// Bytes beyond the capacity of the chain are dropped; a closed pattern restarts.
	assign ctl.pat_shift = is_pat && (closed_q || (len_q < MAXL_C));
	assign ctl.txt_shift = is_txt && (cnt_q < CAP_C);

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		byte_t pat_prev;
		byte_t win_prev;
		if (j == 0) begin : g_head
			assign pat_prev = item.data_byte;
			assign win_prev = item.data_byte;
		end else begin : g_body
			assign pat_prev = pat_w[j-1];
			assign win_prev = win_w[j-1];
		end
		sss_cell #(
			.CELL_IDX (j),
			.LEN_W    (LEN_W)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.pat_in (pat_prev),
			.win_in (win_prev),
			.len    (len_q),
			.pat    (pat_w[j]),
			.win    (win_w[j]),
			.eq     (eq_w[j])
		);
	end

	assign n        = cnt_q + CNT_W'(1);
	assign len_ext  = CNT_W'(len_q);
	assign diff     = n - len_ext;
	assign hit      = ctl.txt_shift && (len_q != '0) && (n >= len_ext)
		&& (diff <= IMAX_C) && (&eq_w);
	assign take_new = hit && (search_last_q || !seen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_last_q <= 1'b0;
		end else if (cfg_we) begin
			search_last_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			closed_q <= 1'b1;
		end else if (is_pat) begin
			if (closed_q) begin
				len_q <= LEN_W'(1);
			end else if (len_q < MAXL_C) begin
				len_q <= len_q + LEN_W'(1);
			end
			closed_q <= item.last;
		end else if (is_txt) begin
			closed_q <= 1'b1;
		end
	end

	// Text state is dropped by a pattern byte and after the end of each text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
		end else if (is_pat || (is_txt && item.last)) begin
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			start_q <= '0;
		end else if (ctl.txt_shift) begin
			cnt_q <= n;
			if (hit) begin
				seen_q <= 1'b1;
			end
			if (take_new) begin
				start_q <= diff[INDEX_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (is_txt && item.last) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_txt && item.last) begin
			res_found_q <= seen_q || hit;
			if (take_new) begin
				res_start_q <= diff[INDEX_BITS-1:0];
			end else begin
				res_start_q <= start_q;
			end
		end
	end

	assign result.valid     = res_valid_q;
	assign result.found     = res_found_q;
	assign result.start_pos = res_start_q;

endmodule

[test/tb_substring_search_first_last.sv]
// Self-checking testbench for the first/last occurrence substring search block.
`timescale 1ns / 1ps

module tb_substring_search_first_last
	import sss_pkg::*;
();

	localparam int MAX_PAT      = 32;
	localparam int IDX_BITS     = 16;
	localparam int IDX_MAX      = (1 << IDX_BITS) - 1;
	localparam int TEXT_CAP     = IDX_MAX + MAX_PAT;
	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE       = 4;
	localparam int RANDOM_ITEMS = 800;
	localparam int PHASES       = 8;

	typedef struct packed {
		logic                found;
		logic [IDX_BITS-1:0] index;
	} report_t;

	typedef struct packed {
		logic    op;
		byte_t   data;
		logic    final_byte;
		logic    typed;
		report_t report;
	} stim_row_t;

	// Rows with typed set carry a report that is obvious by inspection.
	localparam stim_row_t DIRECTED [0:22] = '{
		'{OP_TEXT,    8'h00, 1'b1, 1'b1, '{1'b0, 16'd0}},
		'{OP_PATTERN, 8'hFF, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_PATTERN, 8'h00, 1'b1, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'hFF, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h00, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'hFF, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h00, 1'b1, 1'b1, '{1'b1, 16'd0}},
		'{OP_TEXT,    8'hFF, 1'b1, 1'b1, '{1'b0, 16'd0}},
		'{OP_PATTERN, 8'h41, 1'b1, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h41, 1'b1, 1'b1, '{1'b1, 16'd0}},
		'{OP_TEXT,    8'h42, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h41, 1'b1, 1'b1, '{1'b1, 16'd1}},
		'{OP_PATTERN, 8'h10, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h10, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h10, 1'b1, 1'b1, '{1'b1, 16'd0}},
		'{OP_TEXT,    8'h33, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_PATTERN, 8'h55, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_PATTERN, 8'hAA, 1'b1, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h55, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'hAA, 1'b1, 1'b1, '{1'b1, 16'd0}},
		'{OP_TEXT,    8'h00, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'h55, 1'b0, 1'b0, '{1'b0, 16'd0}},
		'{OP_TEXT,    8'hAA, 1'b1, 1'b0, '{1'b0, 16'd0}}
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cfg_we    = 1'b0;
	logic cfg_wdata = 1'b0;

	sss_in_if item_bus ();
	sss_out_if #(.INDEX_BITS(IDX_BITS)) result_bus ();

	substring_search_first_last #(
		.MAX_PATTERN(MAX_PAT),
		.INDEX_BITS (IDX_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_bus),
		.result   (result_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Search state mirrored from the block; window entry 0 is the newest byte.
	byte_t   pat_mem [MAX_PAT];
	int      pat_len     = 0;
	bit      pat_closed  = 1'b1;
	byte_t   window [MAX_PAT];
	int      text_seen   = 0;
	bit      hit_seen    = 1'b0;
	int      hit_start   = 0;
	bit      report_last = 1'b0;
	report_t expected_reports [$];

	int      failures     = 0;
	int      items_sent   = 0;
	int      stall_cycles = 0;
	bit      tx_bursty    = 1'b0;
	int      burst_left   = 0;
	int      rx_mode      = 0;
	logic [7:0] rx_mask   = 8'hFF;
	logic [7:0] rx_tick   = 8'd0;

	function automatic void clear_text_state();
		foreach (window[k])
			window[k] = 8'h00;
		text_seen = 0;
		hit_seen  = 1'b0;
		hit_start = 0;
	endfunction

	// Advances the mirrored state by one accepted item; returns 1 when a report is due.
	function automatic bit predict_search(input logic op, input byte_t b, input logic lst,
			output report_t rep);
		bit hit;
		int k;
		rep = '0;
		if (op == OP_PATTERN) begin
			if (text_seen != 0 || hit_seen)
				clear_text_state();
			if (pat_closed) begin
				pat_len    = 0;
				pat_closed = 1'b0;
			end
			if (pat_len < MAX_PAT) begin
				pat_mem[pat_len] = b;
				pat_len++;
			end
			if (lst)
				pat_closed = 1'b1;
			return 1'b0;
		end
		pat_closed = 1'b1;
		if (text_seen < TEXT_CAP) begin
			for (k = MAX_PAT - 1; k > 0; k--)
				window[k] = window[k-1];
			window[0] = b;
			text_seen++;
			if (pat_len != 0 && text_seen >= pat_len && text_seen - pat_len <= IDX_MAX) begin
				hit = 1'b1;
				for (k = 0; k < pat_len; k++)
					if (pat_mem[k] != window[pat_len-1-k])
						hit = 1'b0;
				if (hit) begin
					if (report_last || !hit_seen)
						hit_start = text_seen - pat_len;
					hit_seen = 1'b1;
				end
			end
		end
		if (!lst)
			return 1'b0;
		rep.found = hit_seen;
		rep.index = hit_seen ? hit_start[IDX_BITS-1:0] : '0;
		clear_text_state();
		return 1'b1;
	endfunction

	function automatic byte_t pick_byte(input byte_t alpha [4]);
		if ($urandom_range(0, 7) == 0)
			return byte_t'($urandom);
		return alpha[$urandom_range(0, 3)];
	endfunction

	task automatic send_item(input logic op, input byte_t b, input logic lst,
			input logic typed = 1'b0, input report_t typed_rep = '0);
		report_t rep;
		int      gap;
		@(negedge clk);
		if (tx_bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(1, 6);
			item_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid     = 1'b1;
		item_bus.opcode    = op;
		item_bus.data_byte = b;
		item_bus.last      = lst;
		do @(posedge clk); while (!item_bus.ready);
		if (burst_left > 0)
			burst_left--;
		items_sent++;
		if (predict_search(op, b, lst, rep))
			expected_reports.push_back(typed ? typed_rep : rep);
	endtask

	task automatic send_pattern(input byte_t pat [$], input bit close);
		foreach (pat[i])
			send_item(OP_PATTERN, pat[i], close && i == pat.size() - 1);
	endtask

	task automatic send_text(input byte_t txt [$], input bit term);
		foreach (txt[i])
			send_item(OP_TEXT, txt[i], term && i == txt.size() - 1);
	endtask

	// Drops valid and waits until every report has come back and the block has settled.
	task automatic wait_idle();
		@(negedge clk);
		item_bus.valid = 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_mode(input bit v);
		wait_idle();
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we      = 1'b0;
		report_last = v;
	endtask

	// One pattern load (none for kind 0) followed by a few texts that often contain the pattern.
	task automatic random_session();
		byte_t alpha [4];
		byte_t pat [$];
		byte_t txt [$];
		int    plen;
		int    kind;
		int    tlen;
		foreach (alpha[i])
			alpha[i] = byte_t'($urandom);
		kind = $urandom_range(0, 9);
		case ($urandom_range(0, 9))
			0: plen = $urandom_range(5, MAX_PAT);
			1: plen = $urandom_range(MAX_PAT - 1, MAX_PAT + 3);
			default: plen = $urandom_range(1, 4);
		endcase
		repeat (plen) pat.push_back(pick_byte(alpha));
		// Kind 0 keeps the old pattern; kind 1 leaves the new one open for the text to close.
		if (kind != 0)
			send_pattern(pat, kind != 1);
		repeat ($urandom_range(1, 3)) begin
			txt.delete();
			tlen = $urandom_range(1, 24);
			while (txt.size() < tlen) begin
				if (kind != 0 && $urandom_range(0, 4) == 0) begin
					foreach (pat[i])
						txt.push_back(pat[i]);
				end else begin
					txt.push_back(pick_byte(alpha));
				end
			end
			send_text(txt, $urandom_range(0, 11) != 0);
		end
	endtask

	always @(negedge clk) begin
		rx_tick = rx_tick + 8'd1;
		case (rx_mode)
			0: result_bus.ready = 1'b1;
			1: result_bus.ready = rx_mask[rx_tick[2:0]];
			default: result_bus.ready = ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		report_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected report: found %0d, start_pos %0d",
					result_bus.found, result_bus.start_pos);
				failures++;
			end else begin
				want = expected_reports.pop_front();
				if (result_bus.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result_bus.found);
					failures++;
				end
				if (result_bus.start_pos !== want.index) begin
					$error("start_pos: expected %0d, got %0d", want.index,
						result_bus.start_pos);
					failures++;
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which neither channel completes a transfer.
	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles == IDLE_LIMIT) begin
			$display("substring_search_first_last test failed");
			$finish;
		end
	end

	initial begin
		byte_t long_pat [$];
		byte_t txt [$];
		int    phase;
		int    start_count;
		item_bus.valid     = 1'b0;
		item_bus.opcode    = OP_PATTERN;
		item_bus.data_byte = 8'h00;
		item_bus.last      = 1'b0;
		clear_text_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_mode(1'b0);
		foreach (DIRECTED[r])
			send_item(DIRECTED[r].op, DIRECTED[r].data, DIRECTED[r].final_byte,
				DIRECTED[r].typed, DIRECTED[r].report);

		// Pattern longer than the store, closed on a byte that gets dropped.
		tx_bursty = 1'b1;
		rx_mode   = 1;
		rx_mask   = 8'b1011_0110;
		repeat (MAX_PAT + 2) long_pat.push_back(byte_t'($urandom));
		send_pattern(long_pat, 1'b1);
		repeat (5) txt.push_back(byte_t'($urandom));
		for (int i = 0; i < MAX_PAT; i++)
			txt.push_back(long_pat[i]);
		send_text(txt, 1'b1);

		for (phase = 0; phase < PHASES; phase++) begin
			write_mode(phase < 4 ? phase[0] : 1'($urandom_range(0, 1)));
			tx_bursty = ($urandom_range(0, 2) != 0);
			rx_mode   = $urandom_range(0, 2);
			rx_mask   = 8'($urandom_range(1, 255));
			start_count = items_sent;
			while (items_sent - start_count < RANDOM_ITEMS / PHASES)
				random_session();
			// Close any open text so the block is idle before the next register write.
			send_item(OP_TEXT, byte_t'($urandom), 1'b1);
		end

		wait_idle();
		if (failures == 0)
			$display("substring_search_first_last test passed");
		else
			$display("substring_search_first_last test failed");
		$finish;
	end

endmodule
